FILE: hw/rtl/wmv2_php_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wmv2_php_pkg;

	// result kinds
	localparam logic [2:0] KIND_SKIP     = 3'd0;
	localparam logic [2:0] KIND_ROW      = 3'd1;
	localparam logic [2:0] KIND_COL      = 3'd2;
	localparam logic [2:0] KIND_DONE     = 3'd3;
	localparam logic [2:0] KIND_BAD_QUANT = 3'd4;

	// skip modes
	localparam logic [1:0] SKIP_NONE = 2'd0;
	localparam logic [1:0] SKIP_MB   = 2'd1;
	localparam logic [1:0] SKIP_ROW  = 2'd2;
	localparam logic [1:0] SKIP_COL  = 2'd3;

	// flag bit positions
	localparam int FLAG_W        = 7;
	localparam int FLAG_JTYPE    = 0;
	localparam int FLAG_PERMBRL  = 1;
	localparam int FLAG_DC       = 2;
	localparam int FLAG_MV       = 3;
	localparam int FLAG_MSPEL    = 4;
	localparam int FLAG_PERMBABT = 5;
	localparam int FLAG_NORND    = 6;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MB_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MB_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MSPEL_OK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ABT_OK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_JTYPE_OK   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PER_MB_RL_OK = 3'd5;

	localparam int CFG_DATA_W = 8;

	// field widths
	localparam int POS_W   = 7;
	localparam int QSCALE_W = 5;

endpackage

`default_nettype wire

FILE: hw/rtl/wmv2_picture_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Picture header parser, fed one bitstream bit per item.
// Input channel: in_valid/in_ready carry bit_req and frame_start; an item with
// frame_start high begins a new header, abandoning any header in progress.
// Output channel: out_valid/out_ready carry at most one result per input item:
// skip entries, row or column all-skip results, a header-done result with all
// parsed fields, or a bad-quantizer result when the quantizer reads zero.
// Configuration: cfg_wr_en/cfg_addr/cfg_data write the size and enable
// registers; write them only while the parser has no item in
// flight.
// Path: an accepted item passes through the input register, then the state
// update and result register, before its result reaches the output.
// Throughput: one item per cycle while no result waits on out_ready; the
// bit-level state machine and counters update in a single step per item.
// Stall: while a result waits on out_ready, one more item can be taken into
// the input register; further input stalls until the result is taken.
// Reset: the parser goes idle awaiting a frame start, all parsed fields clear,
// the picture size reads one by one macroblock and the enables read 0.
module wmv2_picture_header_parser
	import wmv2_php_pkg::*;
#(
	parameter int MAX_MB_COLS = 128,
	parameter int MAX_MB_ROWS = 128
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  bit_req,
	input  wire logic                  frame_start,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [2:0]                 kind,
	output logic [POS_W-1:0]           mb_x,
	output logic [POS_W-1:0]           mb_y,
	output logic                       skip,
	output logic                       frame_type,
	output logic [QSCALE_W-1:0]        qscale,
	output logic [1:0]                 skip_mode,
	output logic [FLAG_W-1:0]          flags,
	output logic [1:0]                 rl_index,
	output logic [1:0]                 rl_chroma_index,
	output logic [1:0]                 cbp_code,
	output logic [1:0]                 abt_kind,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW  = $clog2(MAX_MB_COLS + 1);
	localparam int RW  = $clog2(MAX_MB_ROWS + 1);
	localparam int CXW0 = (CW > RW) ? CW + 1 : RW + 1;
	localparam int CXW = (CXW0 > CFG_DATA_W + 1) ? CXW0 : CFG_DATA_W + 1;

	typedef enum logic [4:0] {
		PH_IDLE, PH_PTYPE, PH_MARKER, PH_QSCALE, PH_JTYPE, PH_IRLFLAG, PH_IRLC,
		PH_IRLC2, PH_IRLL, PH_IRLL2, PH_IDC, PH_SKIPMODE, PH_MBBITS, PH_ROWHEAD,
		PH_ROWBITS, PH_COLHEAD, PH_COLBITS, PH_CBP, PH_CBP2, PH_MSPEL, PH_ABTFLAG,
		PH_ABT, PH_ABT2, PH_PRLFLAG, PH_PRL, PH_PRL2, PH_PDC, PH_PMV
	} phase_t;

	// configuration
	logic [CFG_DATA_W-1:0] pic_cols_q, pic_rows_q;
	logic                  mspel_ok_q, abt_ok_q, jtype_ok_q, per_mb_rl_ok_q;

	// input register
	logic valid_s1, bit_s1, start_s1;

	// parser state
	phase_t              phase_q;
	logic [2:0]          bits_left_q;
	logic [QSCALE_W-1:0] accum_q;
	logic [CW-1:0]       col_q;
	logic [RW-1:0]       row_q;
	logic [1:0]          skip_mode_q;
	logic                pict_q;
	logic [QSCALE_W-1:0] qscale_q;
	logic [FLAG_W-1:0]   flags_q;
	logic [1:0]          rl_luma_q, rl_chroma_q, cbp_q, abt_q;

	// next values
	phase_t              n_phase, cur;
	logic [2:0]          n_bits;
	logic [QSCALE_W-1:0] n_accum;
	logic [CW-1:0]       n_col, col_inc;
	logic [RW-1:0]       n_row, row_inc;
	logic [1:0]          n_skip_mode;
	logic                n_pict;
	logic [QSCALE_W-1:0] n_qscale;
	logic [FLAG_W-1:0]   n_flags;
	logic [1:0]          n_rl_luma, n_rl_chroma, n_cbp, n_abt;
	logic [1:0]          tri_hi;

	logic                emit, fin;
	logic [2:0]          e_kind;
	logic [POS_W-1:0]    e_x, e_y;
	logic                e_skip;
	logic                tail_cbp, tail_mspel, tail_abt, tail_intra;
	logic [CXW-1:0]      eff_cols, eff_rows;
	logic                col_end, row_end;
	logic                adv;

	assign adv      = !out_valid || out_ready;
	assign in_ready = !valid_s1 || adv;

	always_comb begin
		if (pic_cols_q == '0) begin
			eff_cols = CXW'(1);
		end else if (CXW'(pic_cols_q) > CXW'(MAX_MB_COLS)) begin
			eff_cols = CXW'(MAX_MB_COLS);
		end else begin
			eff_cols = CXW'(pic_cols_q);
		end
		if (pic_rows_q == '0) begin
			eff_rows = CXW'(1);
		end else if (CXW'(pic_rows_q) > CXW'(MAX_MB_ROWS)) begin
			eff_rows = CXW'(MAX_MB_ROWS);
		end else begin
			eff_rows = CXW'(pic_rows_q);
		end
	end

	assign col_inc = col_q + CW'(1);
	assign row_inc = row_q + RW'(1);
	assign col_end = CXW'(col_inc) >= eff_cols;
	assign row_end = CXW'(row_inc) >= eff_rows;
	// second bit of a tri-state code: 1 plus the bit
	assign tri_hi  = 2'd1 + {1'b0, bit_s1};

	always_comb begin
		n_phase     = phase_q;
		n_bits      = bits_left_q;
		n_accum     = accum_q;
		n_col       = col_q;
		n_row       = row_q;
		n_skip_mode = skip_mode_q;
		n_pict      = pict_q;
		n_qscale    = qscale_q;
		n_flags     = flags_q;
		n_rl_luma   = rl_luma_q;
		n_rl_chroma = rl_chroma_q;
		n_cbp       = cbp_q;
		n_abt       = abt_q;
		emit        = 1'b0;
		fin         = 1'b0;
		e_kind      = KIND_SKIP;
		e_x         = '0;
		e_y         = '0;
		e_skip      = 1'b0;
		tail_cbp    = 1'b0;
		tail_mspel  = 1'b0;
		tail_abt    = 1'b0;
		tail_intra  = 1'b0;

		cur = start_s1 ? PH_PTYPE : phase_q;

		unique case (cur)
			PH_PTYPE: begin
				n_pict = bit_s1;
				if (!bit_s1) begin
					n_bits  = 3'd7;
					n_phase = PH_MARKER;
				end else begin
					n_bits  = 3'd5;
					n_accum = '0;
					n_phase = PH_QSCALE;
				end
			end
			PH_MARKER: begin
				n_bits  = bits_left_q - 3'd1;
				n_phase = PH_MARKER;
				if (n_bits == 3'd0) begin
					n_bits  = 3'd5;
					n_accum = '0;
					n_phase = PH_QSCALE;
				end
			end
			PH_QSCALE: begin
				n_accum = {accum_q[QSCALE_W-2:0], bit_s1};
				n_bits  = bits_left_q - 3'd1;
				n_phase = PH_QSCALE;
				if (n_bits == 3'd0) begin
					n_qscale = n_accum;
					if (n_accum == '0) begin
						emit    = 1'b1;
						e_kind  = KIND_BAD_QUANT;
						n_phase = PH_IDLE;
					end else if (!pict_q) begin
						if (jtype_ok_q) begin
							n_phase = PH_JTYPE;
						end else begin
							n_flags[FLAG_JTYPE] = 1'b0;
							tail_intra = 1'b1;
						end
					end else begin
						n_flags[FLAG_JTYPE] = 1'b0;
						n_bits  = 3'd2;
						n_accum = '0;
						n_phase = PH_SKIPMODE;
					end
				end
			end
			PH_JTYPE: begin
				n_flags[FLAG_JTYPE] = bit_s1;
				tail_intra = 1'b1;
			end
			PH_IRLFLAG: begin
				n_flags[FLAG_PERMBRL] = bit_s1;
				n_phase = bit_s1 ? PH_IDC : PH_IRLC;
			end
			PH_IRLC: begin
				n_rl_chroma = 2'd0;
				n_phase = bit_s1 ? PH_IRLC2 : PH_IRLL;
			end
			PH_IRLC2: begin
				n_rl_chroma = tri_hi;
				n_phase = PH_IRLL;
			end
			PH_IRLL: begin
				n_rl_luma = 2'd0;
				n_phase = bit_s1 ? PH_IRLL2 : PH_IDC;
			end
			PH_IRLL2: begin
				n_rl_luma = tri_hi;
				n_phase = PH_IDC;
			end
			PH_IDC: begin
				n_flags[FLAG_DC] = bit_s1;
				fin = 1'b1;
			end
			PH_SKIPMODE: begin
				n_accum = {{(QSCALE_W-2){1'b0}}, accum_q[0], bit_s1};
				n_bits  = bits_left_q - 3'd1;
				n_phase = PH_SKIPMODE;
				if (n_bits == 3'd0) begin
					n_skip_mode = n_accum[1:0];
					n_col = '0;
					n_row = '0;
					unique case (n_accum[1:0])
						SKIP_MB:  n_phase = PH_MBBITS;
						SKIP_ROW: n_phase = PH_ROWHEAD;
						SKIP_COL: n_phase = PH_COLHEAD;
						default:  n_phase = PH_CBP;
					endcase
				end
			end
			PH_MBBITS: begin
				emit   = 1'b1;
				e_kind = KIND_SKIP;
				e_x    = POS_W'(col_q);
				e_y    = POS_W'(row_q);
				e_skip = bit_s1;
				if (col_end) begin
					n_col = '0;
					n_row = row_inc;
					if (row_end) begin
						n_phase = PH_CBP;
					end
				end else begin
					n_col = col_inc;
				end
			end
			PH_ROWHEAD: begin
				if (bit_s1) begin
					emit    = 1'b1;
					e_kind  = KIND_ROW;
					e_y     = POS_W'(row_q);
					e_skip  = 1'b1;
					n_row   = row_inc;
					n_phase = row_end ? PH_CBP : PH_ROWHEAD;
				end else begin
					n_col   = '0;
					n_phase = PH_ROWBITS;
				end
			end
			PH_ROWBITS: begin
				emit   = 1'b1;
				e_kind = KIND_SKIP;
				e_x    = POS_W'(col_q);
				e_y    = POS_W'(row_q);
				e_skip = bit_s1;
				n_col  = col_inc;
				if (col_end) begin
					n_row   = row_inc;
					n_phase = row_end ? PH_CBP : PH_ROWHEAD;
				end
			end
			PH_COLHEAD: begin
				if (bit_s1) begin
					emit    = 1'b1;
					e_kind  = KIND_COL;
					e_x     = POS_W'(col_q);
					e_skip  = 1'b1;
					n_col   = col_inc;
					n_phase = col_end ? PH_CBP : PH_COLHEAD;
				end else begin
					n_row   = '0;
					n_phase = PH_COLBITS;
				end
			end
			PH_COLBITS: begin
				emit   = 1'b1;
				e_kind = KIND_SKIP;
				e_x    = POS_W'(col_q);
				e_y    = POS_W'(row_q);
				e_skip = bit_s1;
				n_row  = row_inc;
				if (row_end) begin
					n_col   = col_inc;
					n_phase = col_end ? PH_CBP : PH_COLHEAD;
				end
			end
			PH_CBP: begin
				if (bit_s1) begin
					n_phase = PH_CBP2;
				end else begin
					n_cbp    = 2'd0;
					tail_cbp = 1'b1;
				end
			end
			PH_CBP2: begin
				n_cbp    = tri_hi;
				tail_cbp = 1'b1;
			end
			PH_MSPEL: begin
				n_flags[FLAG_MSPEL] = bit_s1;
				tail_mspel = 1'b1;
			end
			PH_ABTFLAG: begin
				n_flags[FLAG_PERMBABT] = !bit_s1;
				if (bit_s1) begin
					n_phase = PH_ABT;
				end else begin
					tail_abt = 1'b1;
				end
			end
			PH_ABT: begin
				if (bit_s1) begin
					n_phase = PH_ABT2;
				end else begin
					n_abt    = 2'd0;
					tail_abt = 1'b1;
				end
			end
			PH_ABT2: begin
				n_abt    = tri_hi;
				tail_abt = 1'b1;
			end
			PH_PRLFLAG: begin
				n_flags[FLAG_PERMBRL] = bit_s1;
				n_phase = bit_s1 ? PH_PDC : PH_PRL;
			end
			PH_PRL: begin
				if (bit_s1) begin
					n_phase = PH_PRL2;
				end else begin
					n_rl_luma   = 2'd0;
					n_rl_chroma = 2'd0;
					n_phase     = PH_PDC;
				end
			end
			PH_PRL2: begin
				n_rl_luma   = tri_hi;
				n_rl_chroma = tri_hi;
				n_phase     = PH_PDC;
			end
			PH_PDC: begin
				n_flags[FLAG_DC] = bit_s1;
				n_phase = PH_PMV;
			end
			PH_PMV: begin
				n_flags[FLAG_MV] = bit_s1;
				fin = 1'b1;
			end
			default: begin
				n_phase = PH_IDLE;
			end
		endcase

		// shared tails of the predicted header, in bitstream order
		if (tail_cbp) begin
			if (mspel_ok_q) begin
				n_phase = PH_MSPEL;
			end else begin
				n_flags[FLAG_MSPEL] = 1'b0;
				tail_mspel = 1'b1;
			end
		end
		if (tail_mspel) begin
			if (abt_ok_q) begin
				n_phase = PH_ABTFLAG;
			end else begin
				tail_abt = 1'b1;
			end
		end
		if (tail_abt) begin
			if (per_mb_rl_ok_q) begin
				n_phase = PH_PRLFLAG;
			end else begin
				n_flags[FLAG_PERMBRL] = 1'b0;
				n_phase = PH_PRL;
			end
		end
		// intra header after the j-type flag
		if (tail_intra) begin
			if (n_flags[FLAG_JTYPE]) begin
				fin = 1'b1;
			end else if (per_mb_rl_ok_q) begin
				n_phase = PH_IRLFLAG;
			end else begin
				n_flags[FLAG_PERMBRL] = 1'b0;
				n_phase = PH_IRLC;
			end
		end

		if (fin) begin
			n_flags[FLAG_NORND] = n_pict ? !n_flags[FLAG_NORND] : 1'b1;
			emit    = 1'b1;
			e_kind  = KIND_DONE;
			e_x     = '0;
			e_y     = '0;
			e_skip  = 1'b0;
			n_phase = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pic_cols_q     <= CFG_DATA_W'(1);
			pic_rows_q     <= CFG_DATA_W'(1);
			mspel_ok_q     <= 1'b0;
			abt_ok_q       <= 1'b0;
			jtype_ok_q     <= 1'b0;
			per_mb_rl_ok_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_MB_WIDTH:     pic_cols_q     <= cfg_data;
				CFG_MB_HEIGHT:    pic_rows_q     <= cfg_data;
				CFG_MSPEL_OK:     mspel_ok_q     <= cfg_data[0];
				CFG_ABT_OK:       abt_ok_q       <= cfg_data[0];
				CFG_JTYPE_OK:     jtype_ok_q     <= cfg_data[0];
				CFG_PER_MB_RL_OK: per_mb_rl_ok_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bit_s1   <= bit_req;
			start_s1 <= frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bits_left_q <= '0;
			accum_q     <= '0;
			col_q       <= '0;
			row_q       <= '0;
			skip_mode_q <= '0;
			pict_q      <= 1'b0;
			qscale_q    <= '0;
			flags_q     <= '0;
			rl_luma_q   <= '0;
			rl_chroma_q <= '0;
			cbp_q       <= '0;
			abt_q       <= '0;
			out_valid   <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1 && emit;
			if (valid_s1) begin
				phase_q     <= n_phase;
				bits_left_q <= n_bits;
				accum_q     <= n_accum;
				col_q       <= n_col;
				row_q       <= n_row;
				skip_mode_q <= n_skip_mode;
				pict_q      <= n_pict;
				qscale_q    <= n_qscale;
				flags_q     <= n_flags;
				rl_luma_q   <= n_rl_luma;
				rl_chroma_q <= n_rl_chroma;
				cbp_q       <= n_cbp;
				abt_q       <= n_abt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && emit) begin
			kind            <= e_kind;
			mb_x            <= e_x;
			mb_y            <= e_y;
			skip            <= e_skip;
			frame_type      <= n_pict;
			qscale          <= n_qscale;
			skip_mode       <= n_skip_mode;
			flags           <= n_flags;
			rl_index        <= n_rl_luma;
			rl_chroma_index <= n_rl_chroma;
			cbp_code        <= n_cbp;
			abt_kind        <= n_abt;
		end
	end

endmodule

`default_nettype wire
